// File: sv/aes128_ctr_cipher_macros.svh
// Assertion macros for the AES-128 counter-mode cipher.
// Used by the top level only; no other dependencies.
`ifndef AES128_CTR_CIPHER_MACROS_SVH
`define AES128_CTR_CIPHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ACC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ACC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/acc_pkg.sv
// Shared types, constants and functions for the AES-128 counter-mode cipher.
// No dependencies.
package acc_pkg;

	localparam int unsigned Rounds = 10;
	localparam int unsigned BlockBytes = 16;
	localparam int unsigned ByteMax = 255;

	// Handshake between controller and round cells
	typedef struct packed {
		logic       load;   // start of a block: load counter and key
		logic       run;    // a round step is active this cycle
		logic [3:0] round;  // round number 1..10 for this step
	} round_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] round);
		logic [7:0] r;
		case (round)
			4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
			4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
			4'd9: r = 8'h1b; 4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// File: sv/acc_col_cell.sv
// One state column of the AES round: holds 4 state bytes and 4 round-key bytes.
// Depends on acc_pkg. Columns form a ring: ShiftRows bytes come from neighbors,
// and the key schedule ripples from the previous column's new key word.
module acc_col_cell (
	input  logic                  clk,
	input  acc_pkg::round_ctl_t   ctl,
	input  logic [31:0]           load_state,  // counter word, keyed in this cell with load_key
	input  logic [31:0]           load_key,
	input  logic [31:0]           sub_in,      // shifted bytes from ring neighbors
	input  logic [31:0]           key_prev,    // new key word of previous column
	input  logic [31:0]           last_key_old, // old key word 3, for column 0
	input  logic                  first_col,
	output logic [31:0]           state,
	output logic [31:0]           key,
	output logic [31:0]           key_next
);

	logic [31:0] state_q, key_q;
	logic [7:0]  s0, s1, s2, s3, x;
	logic [31:0] mixed, temp;

	// SubBytes on this column's shifted bytes, then MixColumns except in the last round
	always_comb begin
		s0 = acc_pkg::sbox(sub_in[31:24]);
		s1 = acc_pkg::sbox(sub_in[23:16]);
		s2 = acc_pkg::sbox(sub_in[15:8]);
		s3 = acc_pkg::sbox(sub_in[7:0]);
		x  = s0 ^ s1 ^ s2 ^ s3;
		if (ctl.round == 4'(acc_pkg::Rounds)) begin
			mixed = {s0, s1, s2, s3};
		end else begin
			mixed = {s0 ^ x ^ acc_pkg::xtime(s0 ^ s1), s1 ^ x ^ acc_pkg::xtime(s1 ^ s2),
				s2 ^ x ^ acc_pkg::xtime(s2 ^ s3), s3 ^ x ^ acc_pkg::xtime(s3 ^ s0)};
		end
	end

	// Key schedule word: column 0 uses RotWord/SubWord of old word 3
	always_comb begin
		if (first_col) begin
			temp = {acc_pkg::sbox(last_key_old[23:16]) ^ acc_pkg::rcon(ctl.round),
				acc_pkg::sbox(last_key_old[15:8]), acc_pkg::sbox(last_key_old[7:0]),
				acc_pkg::sbox(last_key_old[31:24])};
		end else begin
			temp = key_prev;
		end
		key_next = key_q ^ temp;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			state_q <= load_state ^ load_key;
			key_q   <= load_key;
		end else if (ctl.run) begin
			state_q <= mixed ^ key_next;
			key_q   <= key_next;
		end
	end

	assign state = state_q;
	assign key   = key_q;

endmodule

// File: sv/acc_ctrl.sv
// Round sequencer and block counter for the AES-128 counter-mode cipher.
// Depends on acc_pkg.
module acc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                first,
	input  logic [127:0]        iv,
	input  logic                out_taken,
	output acc_pkg::round_ctl_t ctl,
	output acc_pkg::state_t     st,
	output logic [127:0]        counter
);

	acc_pkg::state_t st_q;
	logic [3:0]      round_q;
	logic [127:0]    ctr_q;
	logic [127:0]    ctr_use;

	assign ctr_use = first ? iv : ctr_q;

	always_comb begin
		ctl.load  = (st_q == acc_pkg::ST_IDLE) && start;
		ctl.run   = (st_q == acc_pkg::ST_RUN);
		ctl.round = round_q;
	end

	// Counter value fed into the cells on load
	assign counter = ctr_use;
	assign st      = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= acc_pkg::ST_IDLE;
			round_q <= 4'd1;
			ctr_q   <= '0;
		end else begin
			case (st_q)
				acc_pkg::ST_IDLE: begin
					if (start) begin
						ctr_q   <= ctr_use + 128'd1;
						round_q <= 4'd1;
						st_q    <= acc_pkg::ST_RUN;
					end
				end
				acc_pkg::ST_RUN: begin
					round_q <= round_q + 4'd1;
					if (round_q == 4'(acc_pkg::Rounds)) st_q <= acc_pkg::ST_OUT;
				end
				acc_pkg::ST_OUT: begin
					if (out_taken) st_q <= acc_pkg::ST_IDLE;
				end
				default: st_q <= acc_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/aes128_ctr_cipher.sv
// AES-128 counter-mode cipher, top level.
// Depends on acc_pkg, acc_ctrl, acc_col_cell and the assertion macro header.
//
// Usage: write key_high/key_low (index 0/1) and iv_high/iv_low (2/3) through
// the cfg port while idle. Each request on s_axis carries one 16-byte block;
// tuser = first reloads the counter from the IV before this block. The
// keystream (AES of the counter) is XORed in, bytes past byte_count read zero,
// and the counter then steps by one, big-endian, wrapping at 2^128.
// Operation: the accepting edge loads the cells with the initial key addition,
// then rounds 1 to 10 run in a ring of four column cells (one round per
// cycle, key schedule alongside). m_axis_tvalid rises in the output state
// that follows the last round. One block is in flight at a time: the next
// request is accepted only after the result is taken and the controller
// is back in idle. Reset clears the key, IV and counter registers to zero
// and returns the controller to idle. If the receiver stalls the result
// holds on m_axis and s_axis_tready stays low.
`include "aes128_ctr_cipher_macros.svh"
module aes128_ctr_cipher (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // data_high, data_low, byte_count, zero fill
	input  logic         s_axis_tuser,  // first
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata   // result_high, result_low, valid_bytes, zero fill
);

	localparam logic [1:0] RegKeyHigh = 2'd0;
	localparam logic [1:0] RegKeyLow  = 2'd1;
	localparam logic [1:0] RegIvHigh  = 2'd2;
	localparam logic [1:0] RegIvLow   = 2'd3;

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic [127:0] data_q;
	logic [4:0]   count_q;
	logic         accept, out_taken;
	acc_pkg::round_ctl_t ctl;
	acc_pkg::state_t     st;
	logic [127:0] counter, key_in;
	logic [31:0]  col_state [4];
	logic [31:0]  col_key   [4];
	logic [31:0]  col_knext [4];
	logic [127:0] ks, ct;
	logic [4:0]   limit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0; key_low_q <= '0; iv_high_q <= '0; iv_low_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegKeyHigh: key_high_q <= cfg_data;
				RegKeyLow:  key_low_q  <= cfg_data;
				RegIvHigh:  iv_high_q  <= cfg_data;
				RegIvLow:   iv_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (st == acc_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (st == acc_pkg::ST_OUT);
	assign out_taken     = m_axis_tvalid && m_axis_tready;
	assign key_in        = {key_high_q, key_low_q};

	// Block data held while the rounds run; byte 0 in the top bits
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q  <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
			count_q <= s_axis_tdata[132:128];
		end
	end

	acc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(s_axis_tvalid), .first(s_axis_tuser),
		.iv({iv_high_q, iv_low_q}), .out_taken(out_taken), .ctl(ctl), .st(st),
		.counter(counter)
	);

	// Ring of four column cells; column c takes row r byte from column c+r
	for (genvar c = 0; c < 4; c++) begin : g_col
		acc_col_cell u_cell (
			.clk(clk), .ctl(ctl),
			.load_state(counter[127 - 32*c -: 32]),
			.load_key(key_in[127 - 32*c -: 32]),
			.sub_in({col_state[c][31:24], col_state[(c+1)%4][23:16],
				col_state[(c+2)%4][15:8], col_state[(c+3)%4][7:0]}),
			.key_prev(c == 0 ? 32'h0 : col_knext[(c+3)%4]),
			.last_key_old(col_key[3]),
			.first_col(c == 0),
			.state(col_state[c]), .key(col_key[c]), .key_next(col_knext[c])
		);
	end

	// Keystream XOR and byte masking
	assign ks    = {col_state[0], col_state[1], col_state[2], col_state[3]};
	assign limit = (count_q > 5'(acc_pkg::BlockBytes)) ? 5'(acc_pkg::BlockBytes) : count_q;
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			ct[127 - 8*k -: 8] = (5'(k) < limit) ?
				(data_q[127 - 8*k -: 8] ^ ks[127 - 8*k -: 8]) : 8'h00;
		end
	end

	assign m_axis_tdata = {3'b000, count_q, ct[63:0], ct[127:64]};

	`ACC_ASSERT_IMP(a_ready_idle, clk, arst_n, accept, !m_axis_tvalid, "accept while result pending")
	`ACC_ASSERT_NXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
	`ACC_ASSERT_NXT(a_run_after, clk, arst_n, accept, ctl.run && ctl.round == 4'd1, "rounds not started")

endmodule
